@@ rtl/rrdg_pkg.sv @@
// ============================================================================
// rrdg_pkg
// Shared types, constants and helpers for the ranged random dice generator.
// ============================================================================
package rrdg_pkg;

    // Generator and arithmetic widths
    localparam int unsigned STATE_W = 32;
    localparam int unsigned SPAN_W  = 17;   // spans reach 65536
    localparam int unsigned REM_W   = 16;   // remainder stays below the span
    localparam int unsigned VALUE_W = 25;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned SIDES_W = 16;
    localparam int unsigned RANGE_W = 16;
    localparam int unsigned MED_W   = 15;
    localparam int unsigned STEP_W  = $clog2(STATE_W);

    // Input and output bus widths
    localparam int unsigned S_DATA_BITS = COUNT_W + SIDES_W + 2 * RANGE_W + MED_W;
    localparam int unsigned S_DATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int unsigned M_DATA_W    = ((VALUE_W + 7) / 8) * 8;

    // Reset seed and default die limit
    localparam logic [STATE_W-1:0] SEED_RESET   = 32'hDEAD_BEEF;
    localparam int unsigned        MAX_DICE_DEF = 255;

    // Three-draw mean: floor(x/3) = (x * ceil(2^19/3)) >> 19 for x < 2^18
    localparam int unsigned AVG_W      = 18;
    localparam int unsigned AVG_SHIFT  = 19;
    localparam logic [AVG_W-1:0] RECIP3 = 18'd174763;
    localparam int unsigned PROD_W     = 2 * AVG_W;

    // Operation codes carried in s_tuser
    typedef enum logic [1:0] {
        FUNC_SUM    = 2'd0,
        FUNC_RANGED = 2'd1,
        FUNC_AVG    = 2'd2,
        FUNC_COIN   = 2'd3
    } func_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DRAW,
        ST_DIV,
        ST_ACCUM,
        ST_AVG,
        ST_FINISH
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic item_load;   // latch request fields, clear accumulator
        logic draw_start;  // step generator, load divider
        logic div_step;    // one remainder bit
        logic acc_add;     // add finished draw to accumulator
        logic avg_mul;     // reciprocal multiply for the three-draw mean
        logic out_load;    // capture result
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        func_t              func;
        logic [COUNT_W-1:0] count;
        logic               range_bad;
    } status_t;

    // One xorshift step: 13 left, 17 right, 5 left
    function automatic logic [STATE_W-1:0] xorshift(input logic [STATE_W-1:0] s);
        logic [STATE_W-1:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

endpackage

@@ rtl/ranged_random_dice_generator_top.sv @@
// ============================================================================
// ranged_random_dice_generator_top
// Bounded random integers from a 32-bit xorshift generator.
// ============================================================================
//
//  Channel  Dir  Carries
//  s_       in   request: tuser = func, tdata = dice, sides, range, median
//  m_       out  result: tdata = value, tuser = range_error
//  cfg_     in   seed write, reloads the generator state
//
//  Each draw is one generator step and a bit-serial remainder over the 32
//  state bits, then an accumulate; the three-draw mean adds a reciprocal
//  multiply. A coin bit skips the remainder, and a reversed range skips
//  the generator.
//  Synchronous active-low reset loads the state with 0xDEADBEEF.
//  The result register frees the core once loaded; a stalled m_ side holds
//  the next result in its final state until the register drains.
//
module ranged_random_dice_generator_top
    import rrdg_pkg::*;
#(
    parameter int unsigned MAX_DICE = MAX_DICE_DEF
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // request
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // die_count, die_sides, range_low,
                                             // range_high, median, zero fill
    input  logic [1:0]            s_tuser,   // func
    // result
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // value, zero fill
    output logic                  m_tuser,   // range_error
    // seed
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [STATE_W-1:0]    cfg_data
);

    localparam int unsigned SidesLo = COUNT_W;
    localparam int unsigned LowLo   = SidesLo + SIDES_W;
    localparam int unsigned HighLo  = LowLo + RANGE_W;
    localparam int unsigned MedLo   = HighLo + RANGE_W;

    cmd_t               cmd;
    status_t            status;
    logic [VALUE_W-1:0] value;

    assign cfg_ready = 1'b1;

    rrdg_ctrl #(
        .MAX_DICE (MAX_DICE)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rrdg_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .seed_wr   (cfg_valid),
        .seed_data (cfg_data),
        .in_func   (func_t'(s_tuser)),
        .in_count  (s_tdata[COUNT_W-1:0]),
        .in_sides  (s_tdata[SidesLo +: SIDES_W]),
        .in_low    (s_tdata[LowLo +: RANGE_W]),
        .in_high   (s_tdata[HighLo +: RANGE_W]),
        .in_median (s_tdata[MedLo +: MED_W]),
        .cmd       (cmd),
        .status    (status),
        .out_value (value),
        .out_error (m_tuser)
    );

    assign m_tdata = M_DATA_W'(value);

endmodule

@@ rtl/rrdg_datapath.sv @@
// ============================================================================
// rrdg_datapath
// Generator state, request fields, bit-serial remainder unit, accumulator
// and result register.
// ============================================================================
module rrdg_datapath
    import rrdg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // seed writes
    input  logic                 seed_wr,
    input  logic [STATE_W-1:0]   seed_data,
    // request fields
    input  func_t                in_func,
    input  logic [COUNT_W-1:0]   in_count,
    input  logic [SIDES_W-1:0]   in_sides,
    input  logic [RANGE_W-1:0]   in_low,
    input  logic [RANGE_W-1:0]   in_high,
    input  logic [MED_W-1:0]     in_median,
    // control
    input  cmd_t                 cmd,
    output status_t              status,
    // result
    output logic [VALUE_W-1:0]   out_value,
    output logic                 out_error
);

    logic [STATE_W-1:0] state_reg;
    func_t              func_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [SIDES_W-1:0] sides_reg;
    logic [RANGE_W-1:0] low_reg;
    logic [RANGE_W-1:0] high_reg;
    logic [MED_W-1:0]   median_reg;
    logic [STATE_W-1:0] dvd_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [SPAN_W-1:0]  div_reg;
    logic [VALUE_W-1:0] acc_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [VALUE_W-1:0] value_reg;
    logic               error_reg;

    logic [STATE_W-1:0] adv;
    logic               range_bad;
    logic [SPAN_W-1:0]  span;
    logic [SPAN_W-1:0]  diff;
    logic [SPAN_W-1:0]  twice_med;
    logic [SPAN_W-1:0]  trial;
    logic               fits;
    logic [REM_W-1:0]   rem_next;
    logic [VALUE_W-1:0] acc_next;
    logic [VALUE_W-1:0] low_ext;
    logic [VALUE_W-1:0] value_next;

    assign adv       = xorshift(state_reg);
    assign range_bad = $signed(high_reg) < $signed(low_reg);
    assign low_ext   = VALUE_W'($signed(low_reg));

    // Draw span per operation, zero spans act as one
    assign diff      = SPAN_W'($signed(high_reg)) - SPAN_W'($signed(low_reg));
    assign twice_med = {1'b0, median_reg, 1'b0};

    always_comb begin
        unique case (func_reg)
            FUNC_SUM:    span = (sides_reg == '0) ? SPAN_W'(1) : SPAN_W'(sides_reg);
            FUNC_RANGED: span = diff + SPAN_W'(1);
            FUNC_AVG:    span = (median_reg == '0) ? SPAN_W'(1) : twice_med;
            default:     span = SPAN_W'(2);
        endcase
    end

    // Restoring remainder step
    assign trial    = {rem_reg, dvd_reg[STATE_W-1]};
    assign fits     = trial >= div_reg;
    assign rem_next = fits ? REM_W'(trial - div_reg) : REM_W'(trial);

    // Dice modes count faces from one
    always_comb begin
        if (func_reg == FUNC_SUM || func_reg == FUNC_AVG) begin
            acc_next = acc_reg + VALUE_W'(rem_reg) + VALUE_W'(1);
        end else begin
            acc_next = acc_reg + VALUE_W'(rem_reg);
        end
    end

    // Result select
    always_comb begin
        unique case (func_reg)
            FUNC_SUM:    value_next = acc_reg;
            FUNC_RANGED: value_next = range_bad ? low_ext : acc_reg + low_ext;
            FUNC_AVG:    value_next = VALUE_W'(prod_reg[PROD_W-1:AVG_SHIFT]);
            default:     value_next = acc_reg;
        endcase
    end

    // Generator state: seed write wins
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEED_RESET;
        end else if (seed_wr) begin
            state_reg <= seed_data;
        end else if (cmd.draw_start) begin
            state_reg <= adv;
        end
    end

    // Request fields
    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            func_reg   <= in_func;
            count_reg  <= in_count;
            sides_reg  <= in_sides;
            low_reg    <= in_low;
            high_reg   <= in_high;
            median_reg <= in_median;
        end
    end

    // Remainder unit; a coin bit is the low state bit, no remainder steps
    always_ff @(posedge aclk) begin
        if (cmd.draw_start) begin
            dvd_reg <= adv;
            rem_reg <= (func_reg == FUNC_COIN) ? REM_W'(adv[0]) : '0;
            div_reg <= span;
        end else if (cmd.div_step) begin
            dvd_reg <= {dvd_reg[STATE_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    // Accumulator and mean multiply
    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            acc_reg <= '0;
        end else if (cmd.acc_add) begin
            acc_reg <= acc_next;
        end
        if (cmd.avg_mul) begin
            prod_reg <= acc_reg[AVG_W-1:0] * RECIP3;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            value_reg <= value_next;
            error_reg <= (func_reg == FUNC_RANGED) && range_bad;
        end
    end

    assign status.func      = func_reg;
    assign status.count     = count_reg;
    assign status.range_bad = range_bad;
    assign out_value        = value_reg;
    assign out_error        = error_reg;

endmodule

@@ rtl/rrdg_ctrl.sv @@
// ============================================================================
// rrdg_ctrl
// Sequencer: draw count, remainder bit count, handshakes.
// ============================================================================
module rrdg_ctrl
    import rrdg_pkg::*;
#(
    parameter int unsigned MAX_DICE = MAX_DICE_DEF
)
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  status_t  status,
    output cmd_t     cmd
);

    localparam logic [15:0] MaxDice = 16'(MAX_DICE);

    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [COUNT_W-1:0] left_reg, left_next;
    logic               m_tvalid_reg, m_tvalid_next;

    logic [COUNT_W-1:0] count_eff;
    logic [COUNT_W-1:0] count_clamp;
    logic               out_free;

    // Die count: zero acts as one, then limited to MAX_DICE
    assign count_eff   = (status.count == '0) ? COUNT_W'(1) : status.count;
    assign count_clamp = (16'(count_eff) > MaxDice) ? COUNT_W'(MaxDice) : count_eff;
    assign out_free    = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            left_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            left_reg     <= left_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        left_next     = left_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        s_tready      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.item_load = 1'b1;
                    state_next    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // reversed range skips the generator
                if (status.func == FUNC_RANGED && status.range_bad) begin
                    state_next = ST_FINISH;
                end else begin
                    unique case (status.func)
                        FUNC_SUM: left_next = count_clamp;
                        FUNC_AVG: left_next = COUNT_W'(3);
                        default:  left_next = COUNT_W'(1);
                    endcase
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW: begin
                cmd.draw_start = 1'b1;
                step_next      = '0;
                // coin bit needs no remainder
                if (status.func == FUNC_COIN) begin
                    state_next = ST_ACCUM;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(STATE_W - 1)) begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                cmd.acc_add = 1'b1;
                left_next   = left_reg - COUNT_W'(1);
                if (left_reg != COUNT_W'(1)) begin
                    state_next = ST_DRAW;
                end else if (status.func == FUNC_AVG) begin
                    state_next = ST_AVG;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_AVG: begin
                cmd.avg_mul = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH: begin
                // wait for the result register to drain
                if (out_free) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

endmodule
